// File: rtl/nhtl_pkg.sv
// Shared constants, codes and name functions for the name hash table lookup block.
`timescale 1ns / 1ps
`default_nettype none
package nhtl_pkg;

  localparam int unsigned MaxEntries = 4096;
  localparam int unsigned IdxW       = $clog2(MaxEntries);
  localparam int unsigned CntW       = $clog2(MaxEntries + 1);
  localparam int unsigned NameW      = 64;
  localparam int unsigned HashW      = 32;
  localparam logic [HashW-1:0] HashSeed = 32'd5381;

  typedef enum logic [1:0] {
    ActClear  = 2'd0,
    ActAppend = 2'd1,
    ActBuild  = 2'd2,
    ActLookup = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    StsOk       = 2'd0,
    StsNotFound = 2'd1,
    StsFull     = 2'd2
  } status_e;

  // Upper-case a-z up to the first NUL and zero every byte after it.
  function automatic logic [NameW-1:0] canon_name(input logic [NameW-1:0] raw);
    logic [NameW-1:0] res;
    logic             stop;
    logic [7:0]       c;
    res  = '0;
    stop = 1'b0;
    for (int k = 0; k < 8; k++) begin
      c = raw[8*k +: 8];
      if (c == 8'h00) stop = 1'b1;
      if (!stop) begin
        if (c >= 8'h61 && c <= 8'h7A) c = c - 8'h20;
        res[8*k +: 8] = c;
      end
    end
    return res;
  endfunction

  // djb2-style hash (seed 5381, h = (h << 5) ^ h ^ byte) over a canonical name, stopping at the first NUL.
  function automatic logic [HashW-1:0] name_hash(input logic [NameW-1:0] cn);
    logic [HashW-1:0] h;
    logic             stop;
    h    = HashSeed;
    stop = 1'b0;
    for (int k = 0; k < 8; k++) begin
      if (cn[8*k +: 8] == 8'h00) stop = 1'b1;
      if (!stop) h = ((h << 5) ^ h) ^ {24'd0, cn[8*k +: 8]};
    end
    return h;
  endfunction

endpackage
`default_nettype wire

// File: rtl/nhtl_divrem.sv
// Iterative remainder unit: hash modulo entry count, one quotient bit per cycle.
`timescale 1ns / 1ps
`default_nettype none
module nhtl_divrem (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          start_i,
  input  wire logic [nhtl_pkg::HashW-1:0]    dividend_i,
  input  wire logic [nhtl_pkg::CntW-1:0]     divisor_i,
  output logic                               done_o,
  output logic [nhtl_pkg::IdxW-1:0]          rem_o
);

  localparam int unsigned StepW = $clog2(nhtl_pkg::HashW);

  logic                          busy_q;
  logic [StepW-1:0]              step_q;
  logic [nhtl_pkg::HashW-1:0]    dvd_q;
  logic [nhtl_pkg::CntW-1:0]     dvs_q;
  logic [nhtl_pkg::CntW:0]       rem_q;
  logic [nhtl_pkg::CntW:0]       shifted;
  logic [nhtl_pkg::CntW:0]       rem_d;

  // Shift in the next dividend bit and subtract when it fits
  always_comb begin
    shifted = {rem_q[nhtl_pkg::CntW-1:0], dvd_q[nhtl_pkg::HashW-1]};
    if (shifted >= {1'b0, dvs_q}) rem_d = shifted - {1'b0, dvs_q};
    else                          rem_d = shifted;
  end

  // Hold control and run the bit loop
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_o <= 1'b0;
      step_q <= '0;
    end else begin
      done_o <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        step_q <= '0;
      end else if (busy_q) begin
        step_q <= step_q + 1'b1;
        if (step_q == StepW'(nhtl_pkg::HashW - 1)) begin
          busy_q <= 1'b0;
          done_o <= 1'b1;
        end
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q <= dividend_i;
      dvs_q <= divisor_i;
      rem_q <= '0;
    end else if (busy_q) begin
      dvd_q <= {dvd_q[nhtl_pkg::HashW-2:0], 1'b0};
      rem_q <= rem_d;
    end
  end

  assign rem_o = rem_q[nhtl_pkg::IdxW-1:0];

endmodule
`default_nettype wire

// File: rtl/nhtl_store.sv
// Name, chain link and bucket head memories with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module nhtl_store (
  input  wire logic                          clk_i,
  input  wire logic                          name_we_i,
  input  wire logic [nhtl_pkg::IdxW-1:0]     name_waddr_i,
  input  wire logic [nhtl_pkg::NameW-1:0]    name_wdata_i,
  input  wire logic [nhtl_pkg::IdxW-1:0]     name_raddr_i,
  output logic [nhtl_pkg::NameW-1:0]         name_rdata_o,
  input  wire logic                          link_we_i,
  input  wire logic [nhtl_pkg::IdxW-1:0]     link_waddr_i,
  input  wire logic [nhtl_pkg::CntW-1:0]     link_wdata_i,
  input  wire logic [nhtl_pkg::IdxW-1:0]     link_raddr_i,
  output logic [nhtl_pkg::CntW-1:0]          link_rdata_o,
  input  wire logic                          head_we_i,
  input  wire logic [nhtl_pkg::IdxW-1:0]     head_waddr_i,
  input  wire logic [nhtl_pkg::CntW-1:0]     head_wdata_i,
  input  wire logic [nhtl_pkg::IdxW-1:0]     head_raddr_i,
  output logic [nhtl_pkg::CntW-1:0]          head_rdata_o
);

  logic [nhtl_pkg::NameW-1:0] name_mem [nhtl_pkg::MaxEntries];
  logic [nhtl_pkg::CntW-1:0]  link_mem [nhtl_pkg::MaxEntries];
  logic [nhtl_pkg::CntW-1:0]  head_mem [nhtl_pkg::MaxEntries];

  // Write one entry and read one entry per memory each cycle
  always_ff @(posedge clk_i) begin
    if (name_we_i) name_mem[name_waddr_i] <= name_wdata_i;
    name_rdata_o <= name_mem[name_raddr_i];
  end

  always_ff @(posedge clk_i) begin
    if (link_we_i) link_mem[link_waddr_i] <= link_wdata_i;
    link_rdata_o <= link_mem[link_raddr_i];
  end

  always_ff @(posedge clk_i) begin
    if (head_we_i) head_mem[head_waddr_i] <= head_wdata_i;
    head_rdata_o <= head_mem[head_raddr_i];
  end

endmodule
`default_nettype wire

// File: rtl/name_hash_table_lookup.sv
// Top level of the name hash table lookup block: control sequencer and stream ports.
//
// One transaction on the slave stream carries an action (tuser) and an eight-byte
// name (tdata). Every action returns exactly one result transaction on the master
// stream: found, match_index and entry_total in tdata, status in tuser.
// Clear and append go from idle straight to the done state, which loads the result
// register and returns to idle. A lookup without built chains scans from the newest
// entry backwards, with a test state and a compare state per entry examined; with
// chains it first runs the serial remainder unit (hash modulo entry count, one bit a
// cycle) and then walks the chain link by link. A build first empties the bucket
// heads entry by entry, then for each entry reads its name, runs the same remainder
// unit and links the entry into its bucket. Each step of a scan or walk is one read
// of the name and link memories, whose read data is registered.
// Items are handled one at a time; a new item is taken while the previous result
// still waits in the output register. When the receiver stalls, the finished
// result is held and the sequencer waits before overwriting it.
// Reset empties the directory and drops the chains; the memories themselves are
// not cleared, since only entries below the entry count are ever read.
`timescale 1ns / 1ps
`default_nettype none
module name_hash_table_lookup (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [63:0] s_axis_tdata,   // name_bytes[63:0]
  input  wire logic [1:0]  s_axis_tuser,   // action[1:0]
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [31:0]      m_axis_tdata,   // found[0], match_index[12:1], entry_total[25:13]
  output logic [1:0]       m_axis_tuser    // status[1:0]
);

  localparam int unsigned IdxW = nhtl_pkg::IdxW;
  localparam int unsigned CntW = nhtl_pkg::CntW;

  typedef enum logic [3:0] {
    StIdle, StBldClr, StBldName, StBldStart, StBldDiv, StBldHead,
    StLkDiv, StLkHead, StLkTest, StLkCmp, StScTest, StScCmp, StDone
  } state_e;

  state_e                      state_q;
  logic [CntW-1:0]             count_q;
  logic                        chains_q;
  logic [nhtl_pkg::NameW-1:0]  key_q;
  logic [CntW-1:0]             i_q;
  logic [CntW-1:0]             link_q;
  logic [CntW-1:0]             steps_q;
  logic [IdxW-1:0]             bkt_q;
  logic                        r_found_q;
  logic [IdxW-1:0]             r_index_q;
  nhtl_pkg::status_e           r_status_q;
  logic                        m_valid_q;
  logic [31:0]                 m_data_q;
  logic [1:0]                  m_user_q;

  logic                        accept;
  logic [nhtl_pkg::NameW-1:0]  in_canon;
  logic                        div_start;
  logic [nhtl_pkg::HashW-1:0]  div_dvd;
  logic                        div_done;
  logic [IdxW-1:0]             div_rem;

  logic                        name_we, link_we, head_we;
  logic [IdxW-1:0]             name_waddr, link_waddr, head_waddr;
  logic [IdxW-1:0]             name_raddr, head_raddr;
  logic [CntW-1:0]             link_wdata, head_wdata;
  logic [nhtl_pkg::NameW-1:0]  name_rdata;
  logic [CntW-1:0]             link_rdata, head_rdata;

  assign s_axis_tready = (state_q == StIdle);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign in_canon      = nhtl_pkg::canon_name(s_axis_tdata);

  // Start the remainder unit for a chained lookup or for each build entry
  always_comb begin
    div_start = 1'b0;
    div_dvd   = nhtl_pkg::name_hash(name_rdata);
    if (accept && s_axis_tuser == nhtl_pkg::ActLookup && chains_q && count_q != '0) begin
      div_start = 1'b1;
      div_dvd   = nhtl_pkg::name_hash(in_canon);
    end else if (state_q == StBldStart) begin
      div_start = 1'b1;
    end
  end

  nhtl_divrem u_divrem (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dvd),
    .divisor_i  (count_q),
    .done_o     (div_done),
    .rem_o      (div_rem)
  );

  // Drive memory ports from the sequencer state
  always_comb begin
    name_we    = accept && s_axis_tuser == nhtl_pkg::ActAppend &&
                 count_q != CntW'(nhtl_pkg::MaxEntries);
    name_waddr = count_q[IdxW-1:0];
    link_we    = (state_q == StBldHead);
    link_waddr = i_q[IdxW-1:0];
    link_wdata = head_rdata;
    head_we    = (state_q == StBldClr) || (state_q == StBldHead);
    head_waddr = (state_q == StBldClr) ? i_q[IdxW-1:0] : bkt_q;
    head_wdata = (state_q == StBldClr) ? '0 : i_q + 1'b1;
    head_raddr = div_rem;
    name_raddr = i_q[IdxW-1:0];
    if (state_q == StLkTest) name_raddr = IdxW'(link_q - 1'b1);
    else if (state_q == StScTest) name_raddr = IdxW'(i_q - 1'b1);
  end

  nhtl_store u_store (
    .clk_i        (clk_i),
    .name_we_i    (name_we),
    .name_waddr_i (name_waddr),
    .name_wdata_i (in_canon),
    .name_raddr_i (name_raddr),
    .name_rdata_o (name_rdata),
    .link_we_i    (link_we),
    .link_waddr_i (link_waddr),
    .link_wdata_i (link_wdata),
    .link_raddr_i (name_raddr),
    .link_rdata_o (link_rdata),
    .head_we_i    (head_we),
    .head_waddr_i (head_waddr),
    .head_wdata_i (head_wdata),
    .head_raddr_i (head_raddr),
    .head_rdata_o (head_rdata)
  );

  // Sequence the actions and hold the result registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= StIdle;
      count_q    <= '0;
      chains_q   <= 1'b0;
      i_q        <= '0;
      link_q     <= '0;
      steps_q    <= '0;
      bkt_q      <= '0;
      key_q      <= '0;
      r_found_q  <= 1'b0;
      r_index_q  <= '0;
      r_status_q <= nhtl_pkg::StsOk;
      m_valid_q  <= 1'b0;
      m_data_q   <= '0;
      m_user_q   <= '0;
    end else begin
      // Drop the taken result unless the done state reloads the register
      if (m_valid_q && m_axis_tready && state_q != StDone) m_valid_q <= 1'b0;
      unique case (state_q)
        StIdle: begin
          if (accept) begin
            key_q      <= in_canon;
            r_found_q  <= 1'b0;
            r_index_q  <= '0;
            r_status_q <= nhtl_pkg::StsOk;
            i_q        <= '0;
            state_q    <= StDone;
            unique case (s_axis_tuser)
              nhtl_pkg::ActClear: begin
                count_q  <= '0;
                chains_q <= 1'b0;
              end
              nhtl_pkg::ActAppend: begin
                if (count_q == CntW'(nhtl_pkg::MaxEntries)) begin
                  r_status_q <= nhtl_pkg::StsFull;
                end else begin
                  r_index_q <= count_q[IdxW-1:0];
                  count_q   <= count_q + 1'b1;
                  chains_q  <= 1'b0;
                end
              end
              nhtl_pkg::ActBuild: begin
                chains_q <= 1'b0;
                if (count_q != '0) state_q <= StBldClr;
              end
              default: begin
                r_status_q <= nhtl_pkg::StsNotFound;
                if (count_q != '0) begin
                  if (chains_q) begin
                    state_q <= StLkDiv;
                  end else begin
                    i_q     <= count_q;
                    state_q <= StScTest;
                  end
                end
              end
            endcase
          end
        end
        StBldClr: begin
          if (i_q == count_q - 1'b1) begin
            i_q     <= '0;
            state_q <= StBldName;
          end else begin
            i_q <= i_q + 1'b1;
          end
        end
        StBldName:  state_q <= StBldStart;
        StBldStart: state_q <= StBldDiv;
        StBldDiv: begin
          if (div_done) begin
            bkt_q   <= div_rem;
            state_q <= StBldHead;
          end
        end
        StBldHead: begin
          if (i_q == count_q - 1'b1) begin
            chains_q <= 1'b1;
            state_q  <= StDone;
          end else begin
            i_q     <= i_q + 1'b1;
            state_q <= StBldName;
          end
        end
        StLkDiv: begin
          if (div_done) state_q <= StLkHead;
        end
        StLkHead: begin
          link_q  <= head_rdata;
          steps_q <= '0;
          state_q <= StLkTest;
        end
        StLkTest: begin
          if (link_q == '0 || link_q > count_q || steps_q >= count_q) state_q <= StDone;
          else                                                       state_q <= StLkCmp;
        end
        StLkCmp: begin
          if (name_rdata == key_q) begin
            r_found_q  <= 1'b1;
            r_index_q  <= IdxW'(link_q - 1'b1);
            r_status_q <= nhtl_pkg::StsOk;
            state_q    <= StDone;
          end else begin
            link_q  <= link_rdata;
            steps_q <= steps_q + 1'b1;
            state_q <= StLkTest;
          end
        end
        StScTest: begin
          if (i_q == '0) state_q <= StDone;
          else           state_q <= StScCmp;
        end
        StScCmp: begin
          i_q <= i_q - 1'b1;
          if (name_rdata == key_q) begin
            r_found_q  <= 1'b1;
            r_index_q  <= IdxW'(i_q - 1'b1);
            r_status_q <= nhtl_pkg::StsOk;
            state_q    <= StDone;
          end else begin
            state_q <= StScTest;
          end
        end
        StDone: begin
          if (!m_valid_q || m_axis_tready) begin
            m_valid_q <= 1'b1;
            m_data_q  <= {6'd0, count_q, r_index_q, r_found_q};
            m_user_q  <= r_status_q;
            state_q   <= StIdle;
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tuser  = m_user_q;

  // Clear empties the directory at once
  a_clear_empties: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && s_axis_tuser == nhtl_pkg::ActClear |=> count_q == '0 && !chains_q)
    else $error("clear did not empty the directory");

  // Chains only exist over a non-empty directory
  a_chains_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    chains_q |-> count_q != '0)
    else $error("chains valid on empty directory");

  // A found result always carries status ok
  a_found_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_valid_q && m_data_q[0] |-> m_user_q == nhtl_pkg::StsOk)
    else $error("found result with bad status");

  // Entry count never exceeds capacity
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(nhtl_pkg::MaxEntries))
    else $error("entry count beyond capacity");

endmodule
`default_nettype wire

// File: bench/tb_name_hash_table_lookup.sv
// Self-checking bench for the name hash table lookup block: scoreboard and stream drivers.
`timescale 1ns / 1ps
`default_nettype none

// Predicts every result from its own copy of the directory and checks the results in order.
class dir_scoreboard;
  typedef struct packed {
    logic        found;
    logic [11:0] index;
    logic [1:0]  status;
    logic [12:0] total;
  } dir_result_t;

  logic [63:0]  names  [nhtl_pkg::MaxEntries];
  int unsigned  links  [nhtl_pkg::MaxEntries];
  int unsigned  heads  [nhtl_pkg::MaxEntries];
  int unsigned  count;
  bit           chained;
  dir_result_t  pending_q[$];
  int unsigned  errors;
  int unsigned  checked;

  function new();
    count   = 0;
    chained = 0;
    errors  = 0;
    checked = 0;
  endfunction

  // Upper-case a-z up to the first NUL, zero everything after it.
  function logic [63:0] fold(logic [63:0] raw);
    logic [63:0] res;
    logic [7:0]  c;
    res = '0;
    for (int k = 0; k < 8; k++) begin
      c = raw[8*k +: 8];
      if (c == 8'h00) break;
      if (c >= "a" && c <= "z") c = c - 8'h20;
      res[8*k +: 8] = c;
    end
    return res;
  endfunction

  function logic [31:0] djb2x(logic [63:0] raw);
    logic [63:0] cn;
    logic [31:0] h;
    cn = fold(raw);
    h  = 32'd5381;
    for (int k = 0; k < 8; k++) begin
      if (cn[8*k +: 8] == 8'h00) break;
      h = ((h << 5) ^ h) ^ {24'd0, cn[8*k +: 8]};
    end
    return h;
  endfunction

  function bit search(logic [63:0] raw, output int unsigned idx);
    logic [63:0] key;
    int unsigned lnk, steps;
    key = fold(raw);
    idx = 0;
    if (count == 0) return 0;
    if (chained) begin
      lnk   = heads[djb2x(raw) % count];
      steps = 0;
      while (lnk != 0 && lnk <= count && steps < count) begin
        if (fold(names[lnk-1]) == key) begin
          idx = lnk - 1;
          return 1;
        end
        lnk = links[lnk-1];
        steps++;
      end
      return 0;
    end
    for (int i = int'(count) - 1; i >= 0; i--) begin
      if (fold(names[i]) == key) begin
        idx = i;
        return 1;
      end
    end
    return 0;
  endfunction

  // Apply one accepted transaction to the directory and queue its result.
  function void note_input(nhtl_pkg::action_e act, logic [63:0] name);
    dir_result_t r;
    int unsigned idx, b;
    r = '0;
    case (act)
      nhtl_pkg::ActClear: begin
        count   = 0;
        chained = 0;
      end
      nhtl_pkg::ActAppend: begin
        if (count >= nhtl_pkg::MaxEntries) begin
          r.status = nhtl_pkg::StsFull;
        end else begin
          names[count] = name;
          r.index      = count[11:0];
          count++;
          chained = 0;
        end
      end
      nhtl_pkg::ActBuild: begin
        if (count == 0) begin
          chained = 0;
        end else begin
          for (int i = 0; i < count; i++) heads[i] = 0;
          for (int i = 0; i < count; i++) begin
            b        = djb2x(names[i]) % count;
            links[i] = heads[b];
            heads[b] = i + 1;
          end
          chained = 1;
        end
      end
      default: begin
        if (search(name, idx)) begin
          r.found = 1'b1;
          r.index = idx[11:0];
        end else begin
          r.status = nhtl_pkg::StsNotFound;
        end
      end
    endcase
    r.total = count[12:0];
    pending_q.push_back(r);
  endfunction

  function void check_result(logic [31:0] data, logic [1:0] user);
    dir_result_t want, got;
    got = {data[0], data[12:1], user, data[25:13]};
    checked++;
    if (pending_q.size() == 0) begin
      errors++;
      if (errors <= 10) $display("ERROR: result %0d arrived with nothing expected", checked);
      return;
    end
    want = pending_q.pop_front();
    if (got !== want) begin
      errors++;
      if (errors <= 10)
        $display("ERROR: result %0d found %0b/%0b index %0d/%0d status %0d/%0d total %0d/%0d",
                 checked, want.found, got.found, want.index, got.index,
                 want.status, got.status, want.total, got.total);
    end
  endfunction
endclass

module tb_name_hash_table_lookup;

  localparam int unsigned IdleLimit = 20000;

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [63:0] s_axis_tdata;
  logic [1:0]  s_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [31:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;

  dir_scoreboard sb;
  int unsigned   sent_cnt;
  int unsigned   idle_cycles;
  int unsigned   burst_left;
  bit            hold_req;
  bit            no_gaps;
  logic [63:0]   word_pool[12];

  name_hash_table_lookup dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Watch both streams at the rising edge; feed the scoreboard and the watchdog.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (s_axis_tvalid && s_axis_tready) begin
        sb.note_input(nhtl_pkg::action_e'(s_axis_tuser), s_axis_tdata);
        sent_cnt <= sent_cnt + 1;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        sb.check_result(m_axis_tdata, m_axis_tuser);
      end
      if (idle_cycles >= IdleLimit) begin
        $display("Watchdog: no transaction for %0d cycles", IdleLimit);
        $display("FAILED: results differ");
        $finish;
      end
    end
  end

  // Receiver readiness: random stall segments, full-speed segments, and a long hold-off when requested.
  initial begin
    int unsigned seg_len, mode;
    m_axis_tready = 1'b0;
    forever begin
      seg_len = $urandom_range(5, 60);
      mode    = $urandom_range(0, 2);
      repeat (seg_len) begin
        @(negedge clk_i);
        if (hold_req) begin
          m_axis_tready = 1'b0;
          repeat (400) @(negedge clk_i);
          hold_req = 1'b0;
        end
        if (mode == 0) m_axis_tready = 1'b1;
        else if (mode == 1) m_axis_tready = ($urandom_range(0, 3) != 0);
        else m_axis_tready = ($urandom_range(0, 3) == 0);
      end
    end
  end

  // Offer one transaction and hold it until accepted; gaps come between random bursts.
  task automatic send_item(nhtl_pkg::action_e act, logic [63:0] name);
    int unsigned start;
    if (!no_gaps) begin
      if (burst_left == 0) begin
        s_axis_tvalid = 1'b0;
        repeat ($urandom_range(1, 12)) @(negedge clk_i);
        burst_left = $urandom_range(1, 10);
      end
      burst_left--;
    end
    start         = sent_cnt;
    s_axis_tvalid = 1'b1;
    s_axis_tuser  = act;
    s_axis_tdata  = name;
    do @(negedge clk_i); while (sent_cnt == start);
    s_axis_tvalid = 1'b0;
  endtask

  // Pause the sender until every expected result has come back.
  task automatic drain();
    s_axis_tvalid = 1'b0;
    while (sb.pending_q.size() != 0) @(negedge clk_i);
  endtask

  // Pick a pool word in random case with a random byte after its NUL, or a raw value.
  function automatic logic [63:0] pick_name();
    logic [63:0] n;
    logic [7:0]  c;
    bit          past_end;
    if ($urandom_range(0, 7) == 0) return {$urandom, $urandom};
    n        = word_pool[$urandom_range(0, 11)];
    past_end = 1'b0;
    for (int k = 0; k < 8; k++) begin
      c = n[8*k +: 8];
      if (c == 8'h00) past_end = 1'b1;
      if (past_end && k > 0 && n[8*(k-1) +: 8] == 8'h00) c = 8'($urandom_range(0, 255));
      else if (c >= "A" && c <= "Z" && $urandom_range(0, 1)) c = c + 8'h20;
      n[8*k +: 8] = c;
    end
    return n;
  endfunction

  initial begin
    int unsigned wlen, roll, round_len;
    logic [7:0]  c;
    sb            = new();
    sent_cnt      = 0;
    idle_cycles   = 0;
    burst_left    = 0;
    hold_req      = 1'b0;
    no_gaps       = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = nhtl_pkg::ActClear;
    rst_ni        = 1'b0;
    for (int w = 0; w < 12; w++) begin
      word_pool[w] = '0;
      wlen         = $urandom_range(1, 8);
      for (int k = 0; k < wlen; k++) begin
        c = ($urandom_range(0, 5) == 0) ? 8'($urandom_range(32, 126)) : 8'($urandom_range(65, 90));
        word_pool[w][8*k +: 8] = c;
      end
    end
    repeat (3) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed: empty table, case folding, NUL handling, byte-range edges, chains on and off.
    send_item(nhtl_pkg::ActLookup, 64'h0000_0000_0043_4241);
    send_item(nhtl_pkg::ActBuild,  64'h0);
    send_item(nhtl_pkg::ActAppend, 64'h0000_0000_0063_6261);  // "abc"
    send_item(nhtl_pkg::ActAppend, 64'h0000_0000_0043_4241);  // "ABC"
    send_item(nhtl_pkg::ActAppend, 64'hFFEE_DDCC_BBAA_0041);  // "A" with junk after NUL
    send_item(nhtl_pkg::ActAppend, 64'hFFFF_FFFF_FFFF_FFFF);
    send_item(nhtl_pkg::ActAppend, 64'h0);                    // empty name
    send_item(nhtl_pkg::ActAppend, 64'h7A61_5B40_7B60_5A41);  // edge letters A, Z, a, z and their neighbour bytes
    send_item(nhtl_pkg::ActLookup, 64'h0000_0000_0063_4261);  // matches newest "ABC"
    send_item(nhtl_pkg::ActLookup, 64'h1234_5678_9A00_0061);  // "a" with other junk
    send_item(nhtl_pkg::ActLookup, 64'h0);
    send_item(nhtl_pkg::ActLookup, 64'hFFFF_FFFF_FFFF_FFFF);
    send_item(nhtl_pkg::ActLookup, 64'h5A41_5B40_7B60_7A61);  // case-folded edge name
    send_item(nhtl_pkg::ActLookup, 64'h0000_0000_0000_0042);  // miss
    send_item(nhtl_pkg::ActBuild,  64'h0);
    send_item(nhtl_pkg::ActLookup, 64'h0000_0000_0063_6241);
    send_item(nhtl_pkg::ActLookup, 64'h0000_0000_0000_0041);
    send_item(nhtl_pkg::ActLookup, 64'h0);
    send_item(nhtl_pkg::ActLookup, 64'h0000_0000_0000_0042);
    send_item(nhtl_pkg::ActAppend, 64'h0000_0000_0000_0061);  // drops the chains
    send_item(nhtl_pkg::ActLookup, 64'h0000_0000_0000_0041);
    send_item(nhtl_pkg::ActClear,  64'hFFFF_FFFF_FFFF_FFFF);
    send_item(nhtl_pkg::ActLookup, 64'h0);
    drain();

    // Random rounds of clears, appends, builds and lookups on small tables.
    for (int r = 0; r < 30; r++) begin
      if (r == 10) hold_req = 1'b1;
      if (r == 25) drain();
      round_len = $urandom_range(6, 20);
      for (int i = 0; i < round_len; i++) begin
        roll = $urandom_range(0, 99);
        if (roll < 3) send_item(nhtl_pkg::ActClear, {$urandom, $urandom});
        else if (roll < 40) send_item(nhtl_pkg::ActAppend, pick_name());
        else if (roll < 48 && sb.count < 80) send_item(nhtl_pkg::ActBuild, {$urandom, $urandom});
        else send_item(nhtl_pkg::ActLookup, pick_name());
      end
      if (sb.count > 60) send_item(nhtl_pkg::ActClear, 64'h0);
    end
    drain();

    // Larger table back to back, chained lookups, then an append that drops the chains.
    no_gaps = 1'b1;
    send_item(nhtl_pkg::ActClear, 64'h0);
    for (int i = 0; i < 100; i++) send_item(nhtl_pkg::ActAppend, pick_name());
    no_gaps = 1'b0;
    send_item(nhtl_pkg::ActBuild, 64'h0);
    for (int i = 0; i < 16; i++) send_item(nhtl_pkg::ActLookup, pick_name());
    send_item(nhtl_pkg::ActAppend, pick_name());
    for (int i = 0; i < 4; i++) send_item(nhtl_pkg::ActLookup, pick_name());
    send_item(nhtl_pkg::ActClear, 64'h0);
    send_item(nhtl_pkg::ActLookup, pick_name());
    drain();

    repeat (200) @(negedge clk_i);
    $display("Covered %0d transactions: directed cases, random rounds with stalls and a long",
             sent_cnt);
    $display("receiver hold-off, and a 100-entry table with chained and scanned lookups.");
    if (sb.errors == 0 && sb.pending_q.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("%0d mismatches, %0d results missing", sb.errors, sb.pending_q.size());
      $display("FAILED: results differ");
    end
    $finish;
  end
endmodule
`default_nettype wire

// File: name_hash_table_lookup.f
rtl/nhtl_pkg.sv
rtl/nhtl_divrem.sv
rtl/nhtl_store.sv
rtl/name_hash_table_lookup.sv
bench/tb_name_hash_table_lookup.sv
